@@ rtl/rth_pkg.sv @@
`default_nettype none

package rth_pkg;

    // Channel and quotient widths
    localparam int CH_W      = 8;
    localparam int Q_W       = 8;
    localparam int DIV_STEPS = Q_W;

    // Saturation divider: 255*d over max
    localparam int SAT_DW = CH_W;
    localparam int SAT_NW = SAT_DW + Q_W;

    // Hue divider: 255*n over 6*d, with 6*255 needing 11 bits
    localparam int HUE_DW = CH_W + 3;
    localparam int HUE_NW = HUE_DW + Q_W;

    // Request handed from the front end to the divider pipe
    typedef struct packed {
        logic [CH_W-1:0]   val;
        logic [SAT_NW-1:0] sat_num;
        logic [SAT_DW-1:0] sat_den;
        logic [HUE_NW-1:0] hue_num;
        logic [HUE_DW-1:0] hue_den;
    } div_req_t;

    // Working state of one restoring-division step, both dividers side by side
    typedef struct packed {
        logic [CH_W-1:0]   val;
        logic [SAT_DW-1:0] sat_rem;
        logic [Q_W-1:0]    sat_low;
        logic [SAT_DW-1:0] sat_den;
        logic [Q_W-1:0]    sat_q;
        logic [HUE_DW-1:0] hue_rem;
        logic [Q_W-1:0]    hue_low;
        logic [HUE_DW-1:0] hue_den;
        logic [Q_W-1:0]    hue_q;
    } div_stage_t;

endpackage

`default_nettype wire

@@ rtl/rgb_if.sv @@
`default_nettype none

interface rgb_if;
    import rth_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/hsv_if.sv @@
`default_nettype none

interface hsv_if;
    import rth_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] hue_out;
    logic [CH_W-1:0] sat_out;
    logic [CH_W-1:0] val_out;

    modport source (output valid, output hue_out, output sat_out, output val_out,
                    input ready);
    modport sink   (input valid, input hue_out, input sat_out, input val_out,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/rgb_to_hsv_8bit.sv @@
`default_nettype none

// RGB to HSV converter, 8 bits per channel.
// Pipeline: 2 front-end stages, then 8 restoring-division steps, one quotient
// bit per stage, both dividers in step.
// Throughput: one pixel per cycle; stalls hold each stage, bubbles collapse.
// Reset: rst_n asynchronous active low, clears all valid bits; data is not reset.
module rgb_to_hsv_8bit (
    input  logic clk,
    input  logic rst_n,
    rgb_if.sink   pixel,
    hsv_if.source hsv
);
    import rth_pkg::*;

    logic     req_valid;
    logic     req_ready;
    div_req_t req;

    // Max/min, numerator and scaling
    rth_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    // Pipelined dividers for saturation and hue
    rth_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .hsv       (hsv)
    );

endmodule

`default_nettype wire

@@ rtl/rth_front.sv @@
`default_nettype none

module rth_front (
    input  logic              clk,
    input  logic              rst_n,
    rgb_if.sink               pixel,
    output logic              req_valid,
    input  logic              req_ready,
    output rth_pkg::div_req_t req
);
    import rth_pkg::*;

    localparam int NS_W = HUE_DW + 2;

    // Stage 1 registers: max, range, hue numerator
    logic              v1_reg;
    logic [CH_W-1:0]   mx1_reg, mx1_next;
    logic [CH_W-1:0]   d1_reg, d1_next;
    logic [HUE_DW-1:0] n1_reg, n1_next;

    // Stage 2 registers: scaled numerators and divisors
    logic              v2_reg;
    div_req_t          req_reg, req_next;

    logic              rdy1, rdy2;

    // Bubble-collapsing ready chain
    assign rdy2        = !v2_reg || req_ready;
    assign rdy1        = !v1_reg || rdy2;
    assign pixel.ready = rdy1;

    // Stage 1: max/min, range and the wrapped hue numerator
    always_comb
    begin : stage1
        logic [CH_W-1:0]        r, g, b, mn;
        logic signed [NS_W-1:0] r_s, g_s, b_s, d_s, n_s;
        r = pixel.red_in;
        g = pixel.green_in;
        b = pixel.blue_in;
        mx1_next = (r > g) ? r : g;
        if (b > mx1_next)
        begin
            mx1_next = b;
        end
        mn = (r < g) ? r : g;
        if (b < mn)
        begin
            mn = b;
        end
        d1_next = mx1_next - mn;
        r_s = signed'({{(NS_W-CH_W){1'b0}}, r});
        g_s = signed'({{(NS_W-CH_W){1'b0}}, g});
        b_s = signed'({{(NS_W-CH_W){1'b0}}, b});
        d_s = signed'({{(NS_W-CH_W){1'b0}}, d1_next});
        // priority red, green, blue on ties
        if (r == mx1_next)
        begin
            n_s = g_s - b_s;
        end
        else if (g == mx1_next)
        begin
            n_s = (d_s <<< 1) + b_s - r_s;
        end
        else
        begin
            n_s = (d_s <<< 2) + r_s - g_s;
        end
        // wrap into 0 .. 6d-1
        if (n_s < 0)
        begin
            n_s = n_s + (d_s <<< 2) + (d_s <<< 1);
        end
        n1_next = n_s[HUE_DW-1:0];
    end

    // Stage 2: times 255 by shift-subtract, 6d; gray gets divisor one
    always_comb
    begin : stage2
        logic [HUE_DW-1:0] d_w;
        logic              gray;
        d_w  = {{(HUE_DW-CH_W){1'b0}}, d1_reg};
        gray = (d1_reg == '0);
        req_next.val     = mx1_reg;
        req_next.sat_num = {d1_reg, {Q_W{1'b0}}} - {{Q_W{1'b0}}, d1_reg};
        req_next.hue_num = {n1_reg, {Q_W{1'b0}}} - {{Q_W{1'b0}}, n1_reg};
        req_next.sat_den = gray ? SAT_DW'(1) : mx1_reg;
        req_next.hue_den = gray ? HUE_DW'(1) : ((d_w << 2) + (d_w << 1));
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= pixel.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (rdy1 && pixel.valid)
        begin
            mx1_reg <= mx1_next;
            d1_reg  <= d1_next;
            n1_reg  <= n1_next;
        end
        if (rdy2 && v1_reg)
        begin
            req_reg <= req_next;
        end
    end

    assign req_valid = v2_reg;
    assign req       = req_reg;

`ifndef ASSERT_OFF
    // an accepted pixel lands in stage 1
    a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.ready |=> v1_reg)
        else $error("accepted pixel missing from stage 1");
`endif

endmodule

`default_nettype wire

@@ rtl/rth_div_pipe.sv @@
`default_nettype none

module rth_div_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  rth_pkg::div_req_t req,
    hsv_if.source             hsv
);
    import rth_pkg::*;

    localparam int LAST = DIV_STEPS - 1;

    logic             v_reg    [DIV_STEPS];
    logic             v_in     [DIV_STEPS];
    div_stage_t       stg_reg  [DIV_STEPS];
    div_stage_t       stg_in   [DIV_STEPS];
    div_stage_t       stg_next [DIV_STEPS];
    logic [DIV_STEPS:0] rdy;

    assign rdy[DIV_STEPS] = hsv.ready;
    assign req_ready      = rdy[0];

    // Load the first step: upper numerator bits are the starting remainder
    always_comb
    begin
        stg_in[0].val     = req.val;
        stg_in[0].sat_rem = req.sat_num[SAT_NW-1:Q_W];
        stg_in[0].sat_low = req.sat_num[Q_W-1:0];
        stg_in[0].sat_den = req.sat_den;
        stg_in[0].sat_q   = '0;
        stg_in[0].hue_rem = req.hue_num[HUE_NW-1:Q_W];
        stg_in[0].hue_low = req.hue_num[Q_W-1:0];
        stg_in[0].hue_den = req.hue_den;
        stg_in[0].hue_q   = '0;
    end
    assign v_in[0] = req_valid;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        if (k > 0)
        begin : g_link
            assign stg_in[k] = stg_reg[k-1];
            assign v_in[k]   = v_reg[k-1];
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        // One quotient bit for each divider
        always_comb
        begin : step
            logic [SAT_DW:0] st;
            logic [HUE_DW:0] ht;
            logic [SAT_DW:0] sd;
            logic [HUE_DW:0] hd;
            st = {stg_in[k].sat_rem, stg_in[k].sat_low[Q_W-1]};
            ht = {stg_in[k].hue_rem, stg_in[k].hue_low[Q_W-1]};
            sd = st - {1'b0, stg_in[k].sat_den};
            hd = ht - {1'b0, stg_in[k].hue_den};
            stg_next[k] = stg_in[k];
            stg_next[k].sat_low = {stg_in[k].sat_low[Q_W-2:0], 1'b0};
            stg_next[k].hue_low = {stg_in[k].hue_low[Q_W-2:0], 1'b0};
            if (st >= {1'b0, stg_in[k].sat_den})
            begin
                stg_next[k].sat_rem = sd[SAT_DW-1:0];
                stg_next[k].sat_q   = {stg_in[k].sat_q[Q_W-2:0], 1'b1};
            end
            else
            begin
                stg_next[k].sat_rem = st[SAT_DW-1:0];
                stg_next[k].sat_q   = {stg_in[k].sat_q[Q_W-2:0], 1'b0};
            end
            if (ht >= {1'b0, stg_in[k].hue_den})
            begin
                stg_next[k].hue_rem = hd[HUE_DW-1:0];
                stg_next[k].hue_q   = {stg_in[k].hue_q[Q_W-2:0], 1'b1};
            end
            else
            begin
                stg_next[k].hue_rem = ht[HUE_DW-1:0];
                stg_next[k].hue_q   = {stg_in[k].hue_q[Q_W-2:0], 1'b0};
            end
        end

        // Valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                v_reg[k] <= v_in[k];
            end
        end

        // Payload
        always_ff @(posedge clk)
        begin
            if (rdy[k] && v_in[k])
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // Last step doubles as the output register
    assign hsv.valid   = v_reg[LAST];
    assign hsv.hue_out = stg_reg[LAST].hue_q;
    assign hsv.sat_out = stg_reg[LAST].sat_q;
    assign hsv.val_out = stg_reg[LAST].val;

`ifndef ASSERT_OFF
    // a taken request enters step 0 with remainders below the divisors
    a_req_to_step0: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> v_reg[0]
            && (stg_reg[0].sat_rem < stg_reg[0].sat_den)
            && (stg_reg[0].hue_rem < stg_reg[0].hue_den))
        else $error("divider step 0 loaded with bad remainder");

    // hue never reaches the top code
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv.valid |-> (hsv.hue_out != {Q_W{1'b1}}))
        else $error("hue out of range");

    // black gives zero hue and saturation
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        hsv.valid && (hsv.val_out == '0) |-> (hsv.hue_out == '0) && (hsv.sat_out == '0))
        else $error("black pixel with nonzero hue or saturation");
`endif

endmodule

`default_nettype wire

@@ bench/rgb_to_hsv_8bit_tb.sv @@
`default_nettype none

module rgb_to_hsv_8bit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rth_pkg::*;

    localparam int IDLE_PCT    = 26;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 20;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 20;

    typedef logic [CH_W-1:0] chan_t;

    typedef struct packed {
        chan_t hue;
        chan_t sat;
        chan_t val;
    } hsv_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        hsv_t  hsv;
    } pixel_expect_t;

    // Expected-result store: one HSV triple per accepted pixel request
    class hsv_scoreboard;
        pixel_expect_t expected_q[$];
        int errors;
        int pixels_in;
        int results_ok;
        int gray_seen;

        // Integer HSV conversion, max channel chosen by priority red, green, blue
        static function hsv_t convert(chan_t r, chan_t g, chan_t b);
            int   ri;
            int   gi;
            int   bi;
            int   mx;
            int   mn;
            int   d;
            int   n;
            hsv_t px;
            ri = int'(r);
            gi = int'(g);
            bi = int'(b);
            mx = ri;
            if (gi > mx) mx = gi;
            if (bi > mx) mx = bi;
            mn = ri;
            if (gi < mn) mn = gi;
            if (bi < mn) mn = bi;
            d = mx - mn;
            px.val = chan_t'(mx);
            px.sat = '0;
            px.hue = '0;
            if (d != 0)
            begin
                px.sat = chan_t'((255 * d) / mx);
                if (ri == mx)
                    n = gi - bi;
                else if (gi == mx)
                    n = 2 * d + bi - ri;
                else
                    n = 4 * d + ri - gi;
                if (n < 0)
                    n += 6 * d;
                px.hue = chan_t'((255 * n) / (6 * d));
            end
            return px;
        endfunction

        function void note_pixel(chan_t r, chan_t g, chan_t b);
            pixel_expect_t e;
            e.red   = r;
            e.green = g;
            e.blue  = b;
            e.hsv   = convert(r, g, b);
            if (r == g && g == b)
                gray_seen++;
            expected_q.push_back(e);
            pixels_in++;
        endfunction

        function void report(string what, chan_t want, chan_t got, pixel_expect_t e);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch for rgb %0d,%0d,%0d: expected %0d, actual %0d",
                         $realtime, what, e.red, e.green, e.blue, want, got);
        endfunction

        function void check_result(chan_t h, chan_t s, chan_t v);
            pixel_expect_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result: expected none, actual hsv %0d,%0d,%0d",
                             $realtime, h, s, v);
                return;
            end
            e = expected_q.pop_front();
            if (h !== e.hsv.hue) report("hue", e.hsv.hue, h, e);
            if (s !== e.hsv.sat) report("saturation", e.hsv.sat, s, e);
            if (v !== e.hsv.val) report("value", e.hsv.val, v, e);
            if (h === e.hsv.hue && s === e.hsv.sat && v === e.hsv.val)
                results_ok++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   tx_steady;
    bit   rx_steady;
    bit   hold_req;
    int   hold_left;
    int   quiet_cycles;

    hsv_scoreboard sb;

    rgb_if pixel_bus ();
    hsv_if hsv_bus ();

    rgb_to_hsv_8bit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_bus),
        .hsv   (hsv_bus)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Request and result monitors, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && pixel_bus.valid && pixel_bus.ready)
            sb.note_pixel(pixel_bus.red_in, pixel_bus.green_in, pixel_bus.blue_in);
        if (rst_n && hsv_bus.valid && hsv_bus.ready)
            sb.check_result(hsv_bus.hue_out, hsv_bus.sat_out, hsv_bus.val_out);
    end

    // Watchdog on cycles with no traffic on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_bus.valid && pixel_bus.ready) || (hsv_bus.valid && hsv_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no traffic for %0d cycles", $realtime, STALL_LIMIT);
                $display("rgb_to_hsv_8bit test failed");
                $finish;
            end
        end
    end

    // Result side ready: random stalls, steady stretch, long hold-off on demand
    initial
    begin
        hsv_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                hsv_bus.ready <= 1'b0;
            end
            else if (rx_steady)
                hsv_bus.ready <= 1'b1;
            else
                hsv_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one pixel request, with random idle cycles ahead of it
    task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
        while (!tx_steady && $urandom_range(99) < IDLE_PCT)
        begin
            @(negedge clk);
            pixel_bus.valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        pixel_bus.valid    <= 1'b1;
        pixel_bus.red_in   <= r;
        pixel_bus.green_in <= g;
        pixel_bus.blue_in  <= b;
        @(posedge clk);
        while (!pixel_bus.ready)
            @(posedge clk);
    endtask

    // Random pixel, weighted toward gray, tied maxima, narrow range and extremes
    task automatic send_random_pixels(input int count);
        chan_t r;
        chan_t g;
        chan_t b;
        chan_t base;
        repeat (count)
        begin
            r = chan_t'($urandom);
            g = chan_t'($urandom);
            b = chan_t'($urandom);
            case ($urandom_range(9))
                6:
                begin
                    g = r;
                    b = r;
                end
                7:
                begin
                    base = ($urandom_range(1) == 1) ? 8'hFF : chan_t'($urandom);
                    case ($urandom_range(2))
                        0: begin r = base; g = base; end
                        1: begin g = base; b = base; end
                        default: begin r = base; b = base; end
                    endcase
                end
                8:
                begin
                    base = chan_t'($urandom_range(253));
                    r = base + chan_t'($urandom_range(2));
                    g = base + chan_t'($urandom_range(2));
                    b = base + chan_t'($urandom_range(2));
                end
                9:
                begin
                    if ($urandom_range(1) == 1) r = 8'hFF; else r = 8'h00;
                    if ($urandom_range(1) == 1) g = 8'hFF; else g = 8'h00;
                end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Corner pixels: gray, primaries, hue wrap, tied maxima, smallest range
    logic [3*CH_W-1:0] corner_px [24] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFF0001,
        24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h010000,
        24'h000100, 24'h000001, 24'hFFFEFE, 24'hFEFFFE,
        24'hFEFEFF, 24'h020100, 24'h7F80FF, 24'h80007F,
        24'h55AA00, 24'hC0C0BF, 24'h01FF02, 24'hFE01FF
    };

    // Main sequence
    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        hold_req  = 1'b0;
        hold_left = 0;
        quiet_cycles       = 0;
        pixel_bus.valid    = 1'b0;
        pixel_bus.red_in   = '0;
        pixel_bus.green_in = '0;
        pixel_bus.blue_in  = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners
        foreach (corner_px[i])
            send_pixel(corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0]);

        // Random pixels with random stalls on both sides
        send_random_pixels(280);

        // Sender pauses until the pipe is empty
        @(negedge clk);
        pixel_bus.valid <= 1'b0;
        wait_drained();

        // Long result hold-off while requests keep coming, so the input stalls
        tx_steady = 1'b1;
        hold_req  = 1'b1;
        send_random_pixels(100);

        // Full-rate stretch with no idling on either side
        rx_steady = 1'b1;
        send_random_pixels(200);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        send_random_pixels(220);

        @(negedge clk);
        pixel_bus.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Converted %0d pixel requests (%0d gray), %0d results matched.",
                 sb.pixels_in, sb.gray_seen, sb.results_ok);
        $display("Covered corner pixels, tied maxima, random stalls, a long hold-off and a drain.");
        if (sb.errors == 0)
            $display("rgb_to_hsv_8bit test passed");
        else
            $display("rgb_to_hsv_8bit test failed");
        $finish;
    end

endmodule

`default_nettype wire
